// File: rtl/core/ftm_pkg.sv
package ftm_pkg;

    // Stick and thruster pulse width constants
    localparam logic [11:0] NEUTRAL        = 12'd1500;
    localparam logic [12:0] DOUBLE         = 13'd3000;
    localparam logic [11:0] WIDTH_MAX      = 12'd4095;
    localparam logic [10:0] DEADBAND_RESET = 11'd50;

    // Mixing modes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_ROT   = 3'd1;
    localparam logic [2:0] MODE_FWD   = 3'd2;
    localparam logic [2:0] MODE_DIAG  = 3'd3;
    localparam logic [2:0] MODE_BACK  = 3'd4;
    localparam logic [2:0] MODE_SIDE  = 3'd5;

    // One command item
    typedef struct packed {
        logic [11:0] rotate_cmd;
        logic [11:0] forward_cmd;
        logic [11:0] vertical_cmd;
        logic [11:0] roll_cmd;
        logic        sideways;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [11:0] thruster_a;
        logic [11:0] thruster_b;
        logic [11:0] thruster_c;
        logic [11:0] thruster_d;
        logic [11:0] vertical_out;
        logic [11:0] roll_out;
        logic [2:0]  mix_mode;
    } t_res;

    // Saturate a signed mixed value to the pulse width range
    function automatic logic [11:0] clamp_width(input logic signed [13:0] v);
        logic [11:0] res;
        if (v < 14'sd0) begin
            res = 12'd0;
        end else if (v > $signed({2'b00, WIDTH_MAX})) begin
            res = WIDTH_MAX;
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/ftm_snap.sv
module ftm_snap (
    input  logic [10:0] i_deadband,
    input  logic [11:0] i_width,
    output logic [11:0] o_width
);
    import ftm_pkg::*;

    logic signed [13:0] w_lo;
    logic signed [13:0] w_hi;
    logic signed [13:0] w_val;

    // Bounds of the neutral zone, signed so a wide deadband goes below zero
    assign w_lo  = $signed({2'b00, NEUTRAL}) - $signed({3'b000, i_deadband});
    assign w_hi  = $signed({2'b00, NEUTRAL}) + $signed({3'b000, i_deadband});
    assign w_val = $signed({2'b00, i_width});

    // Snap widths strictly inside the zone to neutral
    assign o_width = (w_val > w_lo && w_val < w_hi) ? NEUTRAL : i_width;

endmodule

// File: rtl/core/ftm_mixer.sv
module ftm_mixer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [10:0]   i_deadband,
    input  ftm_pkg::t_cmd i_cmd,
    output ftm_pkg::t_res o_res
);
    import ftm_pkg::*;

    // Comparison patterns {r > f, r + f > 3000, r > 1500, f > 1500}
    localparam logic [3:0] PAT_ROT_LO  = 4'b0000;
    localparam logic [3:0] PAT_ROT_HI  = 4'b1111;
    localparam logic [3:0] PAT_FWD_LO  = 4'b0111;
    localparam logic [3:0] PAT_FWD_HI  = 4'b1000;
    localparam logic [3:0] PAT_DIAG_LO = 4'b0101;
    localparam logic [3:0] PAT_DIAG_HI = 4'b1010;
    localparam logic [3:0] PAT_BACK_LO = 4'b0001;
    localparam logic [3:0] PAT_BACK_HI = 4'b1110;

    logic [2:0]         r_mode;
    logic [2:0]         n_mode;
    logic [11:0]        w_rot;
    logic [11:0]        w_fwd;
    logic [11:0]        w_vert;
    logic [11:0]        w_roll;
    logic [12:0]        w_sum;
    logic [3:0]         w_pat;
    logic signed [13:0] w_r;
    logic signed [13:0] w_f;
    logic signed [13:0] w_t_a;
    logic signed [13:0] w_t_b;
    logic signed [13:0] w_t_c;
    logic signed [13:0] w_t_d;

    // Deadband snapping of all four sticks
    ftm_snap u_snap_rot  (.i_deadband(i_deadband), .i_width(i_cmd.rotate_cmd),
                          .o_width(w_rot));
    ftm_snap u_snap_fwd  (.i_deadband(i_deadband), .i_width(i_cmd.forward_cmd),
                          .o_width(w_fwd));
    ftm_snap u_snap_vert (.i_deadband(i_deadband), .i_width(i_cmd.vertical_cmd),
                          .o_width(w_vert));
    ftm_snap u_snap_roll (.i_deadband(i_deadband), .i_width(i_cmd.roll_cmd),
                          .o_width(w_roll));

    // Build the comparison pattern
    assign w_sum = {1'b0, w_rot} + {1'b0, w_fwd};
    assign w_pat = {w_rot > w_fwd, w_sum > DOUBLE, w_rot > NEUTRAL, w_fwd > NEUTRAL};

    // Pick the mode; unlisted patterns keep the previous one
    always_comb begin
        n_mode = r_mode;
        if (i_cmd.sideways) begin
            n_mode = MODE_SIDE;
        end else begin
            case (w_pat)
                PAT_ROT_LO, PAT_ROT_HI:   n_mode = MODE_ROT;
                PAT_FWD_LO, PAT_FWD_HI:   n_mode = MODE_FWD;
                PAT_DIAG_LO, PAT_DIAG_HI: n_mode = MODE_DIAG;
                PAT_BACK_LO, PAT_BACK_HI: n_mode = MODE_BACK;
                default:                  n_mode = r_mode;
            endcase
        end
    end

    assign w_r = $signed({2'b00, w_rot});
    assign w_f = $signed({2'b00, w_fwd});

    // Mix rotate and forward into the four thrusters. A mode once chosen
    // never returns to none, so the held values in mode none are the
    // reset zeros.
    always_comb begin
        case (n_mode)
            MODE_ROT: begin
                w_t_a = w_r;
                w_t_b = w_r;
                w_t_c = $signed({2'b00, NEUTRAL}) - w_r + w_f;
                w_t_d = w_t_c;
            end
            MODE_FWD: begin
                w_t_a = w_f;
                w_t_b = w_f;
                w_t_c = $signed({2'b00, NEUTRAL}) - w_r + w_f;
                w_t_d = w_t_c;
            end
            MODE_DIAG: begin
                w_t_a = w_r + w_f - $signed({2'b00, NEUTRAL});
                w_t_b = w_t_a;
                w_t_c = w_f;
                w_t_d = w_f;
            end
            MODE_BACK: begin
                w_t_a = w_r + w_f - $signed({2'b00, NEUTRAL});
                w_t_b = w_t_a;
                w_t_c = $signed({1'b0, DOUBLE}) - w_r;
                w_t_d = w_t_c;
            end
            MODE_SIDE: begin
                w_t_a = w_r;
                w_t_b = $signed({1'b0, DOUBLE}) - w_r;
                w_t_c = w_r;
                w_t_d = w_t_b;
            end
            default: begin
                w_t_a = 14'sd0;
                w_t_b = 14'sd0;
                w_t_c = 14'sd0;
                w_t_d = 14'sd0;
            end
        endcase
    end

    // Saturate and pack the result
    always_comb begin
        o_res.thruster_a   = clamp_width(w_t_a);
        o_res.thruster_b   = clamp_width(w_t_b);
        o_res.thruster_c   = clamp_width(w_t_c);
        o_res.thruster_d   = clamp_width(w_t_d);
        o_res.vertical_out = w_vert;
        o_res.roll_out     = w_roll;
        o_res.mix_mode     = n_mode;
    end

    // Commit the mode when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_adv) begin
            r_mode <= n_mode;
        end
    end

`ifndef SYNTHESIS
    a_mode_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_mode != MODE_NONE) |=> r_mode != MODE_NONE)
        else $error("mixing mode fell back to none");

    a_side_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_adv && i_cmd.sideways) |=> r_mode == MODE_SIDE)
        else $error("sideways item did not select mode 5");
`endif

endmodule

// File: rtl/core/four_thruster_mixer_unit.sv
// Four-thruster mixer. Each command transfer carries rotate, forward,
// vertical and roll pulse widths (neutral 1500) and a sideways flag; each
// produces exactly one result transfer with four thruster widths, the snapped
// vertical and roll widths and the mixing mode in force. A result becomes
// valid once its item has left the input register: the input register feeds
// deadband snapping, mode choice and mixing, which load the result register
// when it is free. One item is taken per cycle while the result side does
// not stall. The deadband register (reset 50) is written through the
// configuration channel, which is always ready; write it only while idle.
module four_thruster_mixer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ftm_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output ftm_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [10:0]   i_cfg_data
);
    import ftm_pkg::*;

    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic        r_out_valid;
    t_res        r_out_res;
    logic [10:0] r_deadband;
    t_res        w_mix_res;
    logic        w_out_adv;
    logic        w_s1_adv;
    logic        w_in_xfer;

    // Handshake: result register frees up when empty or taken
    assign w_out_adv = !r_out_valid || !i_stall;
    assign w_s1_adv  = r_s1_valid && w_out_adv;
    assign o_stall   = r_s1_valid && !w_out_adv;
    assign w_in_xfer = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_res       = r_out_res;

    ftm_mixer u_mixer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_s1_adv),
        .i_deadband (r_deadband),
        .i_cmd      (r_s1_cmd),
        .o_res      (w_mix_res)
    );

    // Control state and the deadband register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_deadband  <= DEADBAND_RESET;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_deadband <= i_cfg_data;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_cmd <= i_cmd;
        end
        if (w_s1_adv) begin
            r_out_res <= w_mix_res;
        end
    end

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_in_xfer) |=> r_s1_valid)
        else $error("accepted item not held in input register");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_s1_valid && r_out_valid && i_stall) |=> (r_s1_valid && o_valid))
        else $error("item dropped while result side stalls");
`endif

endmodule
